### src/kmpd_pkg.sv
`default_nettype none
package kmpd_pkg;

  localparam int unsigned MAP_ENTRIES = 115;

  localparam logic [7:0] HDR_MIN_RESET = 8'd248;
  localparam logic [9:0] X_LIMIT_RESET = 10'd640;
  localparam logic [9:0] Y_LIMIT_RESET = 10'd400;
  localparam logic [9:0] POS_X_RESET = 10'd320;
  localparam logic [9:0] POS_Y_RESET = 10'd200;

  localparam logic [1:0] CFG_HDR_MIN = 2'd0;
  localparam logic [1:0] CFG_X_LIMIT = 2'd1;
  localparam logic [1:0] CFG_Y_LIMIT = 2'd2;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_POP = 1'b1;

  typedef enum logic [2:0] {
    CMD_POP,
    CMD_MAKE,
    CMD_BREAK,
    CMD_HEADER,
    CMD_DX,
    CMD_DY
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic [7:0] data;
  } cmd_t;

  typedef struct packed {
    logic [7:0] hdr_min;
    logic [9:0] x_limit;
    logic [9:0] y_limit;
  } cfg_t;

  function automatic logic [7:0] scan_to_ascii(input logic [7:0] code);
    logic [7:0] ch;
    ch = 8'h00;
    if (code < 8'(MAP_ENTRIES) && !code[7]) begin
      case (code[6:0])
        7'd1:   ch = 8'h1B;
        7'd2:   ch = 8'h31;
        7'd3:   ch = 8'h32;
        7'd4:   ch = 8'h33;
        7'd5:   ch = 8'h34;
        7'd6:   ch = 8'h35;
        7'd7:   ch = 8'h36;
        7'd8:   ch = 8'h37;
        7'd9:   ch = 8'h38;
        7'd10:  ch = 8'h39;
        7'd11:  ch = 8'h30;
        7'd12:  ch = 8'h2D;
        7'd13:  ch = 8'h3D;
        7'd14:  ch = 8'h08;
        7'd15:  ch = 8'h09;
        7'd16:  ch = 8'h71;
        7'd17:  ch = 8'h77;
        7'd18:  ch = 8'h65;
        7'd19:  ch = 8'h72;
        7'd20:  ch = 8'h74;
        7'd21:  ch = 8'h79;
        7'd22:  ch = 8'h75;
        7'd23:  ch = 8'h69;
        7'd24:  ch = 8'h6F;
        7'd25:  ch = 8'h70;
        7'd26:  ch = 8'h5B;
        7'd27:  ch = 8'h5D;
        7'd28:  ch = 8'h0D;
        7'd30:  ch = 8'h61;
        7'd31:  ch = 8'h73;
        7'd32:  ch = 8'h64;
        7'd33:  ch = 8'h66;
        7'd34:  ch = 8'h67;
        7'd35:  ch = 8'h68;
        7'd36:  ch = 8'h6A;
        7'd37:  ch = 8'h6B;
        7'd38:  ch = 8'h6C;
        7'd39:  ch = 8'h3B;
        7'd40:  ch = 8'h27;
        7'd41:  ch = 8'h60;
        7'd43:  ch = 8'h5C;
        7'd44:  ch = 8'h7A;
        7'd45:  ch = 8'h78;
        7'd46:  ch = 8'h63;
        7'd47:  ch = 8'h76;
        7'd48:  ch = 8'h62;
        7'd49:  ch = 8'h6E;
        7'd50:  ch = 8'h6D;
        7'd51:  ch = 8'h2C;
        7'd52:  ch = 8'h2E;
        7'd53:  ch = 8'h2F;
        7'd57:  ch = 8'h20;
        7'd74:  ch = 8'h2D;
        7'd78:  ch = 8'h2B;
        7'd83:  ch = 8'h7F;
        7'd97:  ch = 8'h28;
        7'd98:  ch = 8'h29;
        7'd99:  ch = 8'h2F;
        7'd100: ch = 8'h2A;
        7'd101: ch = 8'h37;
        7'd102: ch = 8'h38;
        7'd103: ch = 8'h39;
        7'd104: ch = 8'h34;
        7'd105: ch = 8'h35;
        7'd106: ch = 8'h36;
        7'd107: ch = 8'h31;
        7'd108: ch = 8'h32;
        7'd109: ch = 8'h33;
        7'd110: ch = 8'h30;
        7'd111: ch = 8'h2E;
        7'd112: ch = 8'h0D;
        default: ch = 8'h00;
      endcase
    end
    return ch;
  endfunction

endpackage
`default_nettype wire

### src/kmpd_ifs.sv
`default_nettype none
interface kmpd_req_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [7:0] data_byte;
  modport source (output valid, output operation, output data_byte, input ready);
  modport sink (input valid, input operation, input data_byte, output ready);
endinterface

interface kmpd_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] popped_key;
  logic       pop_valid;
  logic       pending;
  logic [7:0] next_key;
  logic [8:0] queue_fill;
  logic [9:0] pointer_x;
  logic [9:0] pointer_y;
  logic       key_held;
  logic       overflow;
  modport source (
    output valid, output popped_key, output pop_valid, output pending,
    output next_key, output queue_fill, output pointer_x, output pointer_y,
    output key_held, output overflow, input ready
  );
  modport sink (
    input valid, input popped_key, input pop_valid, input pending,
    input next_key, input queue_fill, input pointer_x, input pointer_y,
    input key_held, input overflow, output ready
  );
endinterface

interface kmpd_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [9:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

### src/kmpd_ram.sv
`default_nettype none
module kmpd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

### src/kmpd_front.sv
`default_nettype none
module kmpd_front (
  input  logic            clk,
  input  logic            rst,
  kmpd_req_if.sink        req,
  input  logic [7:0]      hdr_min,
  output logic            cmd_valid,
  output kmpd_pkg::cmd_t  cmd,
  input  logic            cmd_ready
);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_DX,
    PH_DY
  } phase_t;

  phase_t phase;
  phase_t phase_next;

  assign req.ready = cmd_ready;
  assign cmd_valid = req.valid;

  always_comb begin
    phase_next = phase;
    cmd.data = req.data_byte;
    cmd.kind = kmpd_pkg::CMD_POP;
    if (req.operation == kmpd_pkg::OP_BYTE) begin
      unique case (phase)
        PH_IDLE: begin
          if (req.data_byte >= hdr_min) begin
            cmd.kind = kmpd_pkg::CMD_HEADER;
            phase_next = PH_DX;
          end else if (!req.data_byte[7]) begin
            cmd.kind = kmpd_pkg::CMD_MAKE;
            cmd.data = kmpd_pkg::scan_to_ascii(req.data_byte);
          end else begin
            cmd.kind = kmpd_pkg::CMD_BREAK;
          end
        end
        PH_DX: begin
          cmd.kind = kmpd_pkg::CMD_DX;
          phase_next = PH_DY;
        end
        default: begin
          cmd.kind = kmpd_pkg::CMD_DY;
          phase_next = PH_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
    end else if (req.valid && cmd_ready) begin
      phase <= phase_next;
    end
  end

endmodule
`default_nettype wire

### src/kmpd_cmd_queue.sv
`default_nettype none
module kmpd_cmd_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push_valid,
  output logic            push_ready,
  input  kmpd_pkg::cmd_t  push_cmd,
  output logic            pop_valid,
  input  logic            pop_ready,
  output kmpd_pkg::cmd_t  pop_cmd
);

  kmpd_pkg::cmd_t slots [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     fill;
  logic           do_push;
  logic           do_pop;

  assign push_ready = (fill != 2'd2);
  assign pop_valid  = (fill != 2'd0);
  assign pop_cmd    = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_cmd;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      fill <= fill + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule
`default_nettype wire

### src/kmpd_back.sv
`default_nettype none
module kmpd_back #(
  parameter int QUEUE_DEPTH = 256
) (
  input  logic            clk,
  input  logic            rst,
  input  kmpd_pkg::cfg_t  cfg,
  input  logic            cmd_valid,
  output logic            cmd_ready,
  input  kmpd_pkg::cmd_t  cmd,
  kmpd_rsp_if.source      rsp
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  function automatic logic [9:0] clamp_move(input logic [9:0] pos, input logic [7:0] d,
                                            input logic [9:0] lim);
    logic signed [11:0] sum;
    logic [9:0]         res;
    sum = $signed({2'b00, pos}) + $signed({{4{d[7]}}, d});
    if (sum < 12'sd0) begin
      res = '0;
    end else if (sum > $signed({2'b00, lim})) begin
      res = lim;
    end else begin
      res = sum[9:0];
    end
    return res;
  endfunction

  // queue and pointer state
  logic [AW-1:0] rp, rp_next;
  logic [AW-1:0] wp, wp_next;
  logic [CW-1:0] count, count_next;
  logic [9:0]    pos_x, pos_x_next;
  logic [9:0]    pos_y, pos_y_next;
  logic          held, held_next;
  logic          ovf, ovf_next;
  logic          is_push, full, do_push, do_pop, fire;

  // read stage
  logic          p1_valid;
  logic          p1_pop;
  logic [CW-1:0] p1_count;
  logic [9:0]    p1_x;
  logic [9:0]    p1_y;
  logic          p1_held;
  logic          p1_ovf;
  logic          p1_byp;
  logic [7:0]    p1_byp_data;
  logic          p1_adv;
  logic [7:0]    rdata;
  logic [7:0]    head_key;

  assign p1_adv    = p1_valid && (!rsp.valid || rsp.ready);
  assign cmd_ready = !p1_valid || p1_adv;
  assign fire      = cmd_valid && cmd_ready;

  always_comb begin
    is_push    = (cmd.kind == kmpd_pkg::CMD_MAKE) || (cmd.kind == kmpd_pkg::CMD_HEADER);
    full       = (count == CW'(QUEUE_DEPTH));
    do_push    = is_push && !full;
    do_pop     = (cmd.kind == kmpd_pkg::CMD_POP) && (count != '0);
    ovf_next   = ovf || (is_push && full);
    rp_next    = rp;
    wp_next    = wp;
    if (do_pop) begin
      rp_next = (rp == AW'(QUEUE_DEPTH - 1)) ? '0 : rp + 1'b1;
    end
    if (do_push) begin
      wp_next = (wp == AW'(QUEUE_DEPTH - 1)) ? '0 : wp + 1'b1;
    end
    count_next = count + CW'(do_push) - CW'(do_pop);
    held_next  = held;
    pos_x_next = pos_x;
    pos_y_next = pos_y;
    case (cmd.kind)
      kmpd_pkg::CMD_MAKE:  held_next = 1'b1;
      kmpd_pkg::CMD_BREAK: held_next = 1'b0;
      kmpd_pkg::CMD_DX:    pos_x_next = clamp_move(pos_x, cmd.data, cfg.x_limit);
      kmpd_pkg::CMD_DY:    pos_y_next = clamp_move(pos_y, cmd.data, cfg.y_limit);
      default: ;
    endcase
  end

  kmpd_ram #(
    .WIDTH (8),
    .DEPTH (QUEUE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (fire && do_push),
    .waddr (wp),
    .wdata (cmd.data),
    .re    (fire),
    .raddr (rp_next),
    .rdata (rdata)
  );

  always_comb begin
    head_key = '0;
    if (p1_count != '0) begin
      head_key = p1_byp ? p1_byp_data : rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rp       <= '0;
      wp       <= '0;
      count    <= '0;
      pos_x    <= kmpd_pkg::POS_X_RESET;
      pos_y    <= kmpd_pkg::POS_Y_RESET;
      held     <= 1'b0;
      ovf      <= 1'b0;
      p1_valid <= 1'b0;
    end else begin
      if (fire) begin
        rp    <= rp_next;
        wp    <= wp_next;
        count <= count_next;
        pos_x <= pos_x_next;
        pos_y <= pos_y_next;
        held  <= held_next;
        ovf   <= ovf_next;
      end
      if (fire) begin
        p1_valid <= 1'b1;
      end else if (p1_adv) begin
        p1_valid <= 1'b0;
      end
    end
    if (fire) begin
      p1_pop      <= do_pop;
      p1_count    <= count_next;
      p1_x        <= pos_x_next;
      p1_y        <= pos_y_next;
      p1_held     <= held_next;
      p1_ovf      <= ovf_next;
      p1_byp      <= do_push && (wp == rp_next);
      p1_byp_data <= cmd.data;
    end
  end

  // the popped entry is the head reported with the previous result
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid      <= 1'b0;
      rsp.next_key   <= '0;
    end else if (p1_adv) begin
      rsp.valid      <= 1'b1;
      rsp.next_key   <= head_key;
    end else if (rsp.ready) begin
      rsp.valid      <= 1'b0;
    end
    if (p1_adv) begin
      rsp.popped_key <= p1_pop ? rsp.next_key : 8'h00;
      rsp.pop_valid  <= p1_pop;
      rsp.pending    <= (p1_count != '0);
      rsp.queue_fill <= 9'(p1_count);
      rsp.pointer_x  <= p1_x;
      rsp.pointer_y  <= p1_y;
      rsp.key_held   <= p1_held;
      rsp.overflow   <= p1_ovf;
    end
  end

endmodule
`default_nettype wire

### src/keyboard_mouse_packet_decoder.sv
// keyboard and relative mouse packet decoder
// req channel: operation 0 carries a received byte in data_byte, operation 1
// asks to pop the oldest queued key. every request gives exactly one result
// on the rsp channel with the pop outcome, queue head and fill, pointer
// position, key-held and sticky overflow flags.
// cfg channel: index 0 mouse header threshold, 1 x limit, 2 y limit; always
// ready, other indexes ignored. write only while no request is in flight.
// a request is classified on entry (scancode mapping, packet phase) and goes
// through a two-entry command queue to the execution side, which updates the
// key store and pointer, then reads the new queue head from the store.
// a request passes through the command queue, the read stage and the result register in turn.
// throughput: one request per cycle while rsp takes results; the read stage
// register lets a new request in while a result waits.
// when rsp is stalled the command queue fills and req.ready falls.
// reset empties the key queue, clears the flags, centres the pointer at
// 320,200 and restores the register defaults. no clearing pass is needed.
`default_nettype none
module keyboard_mouse_packet_decoder #(
  parameter int QUEUE_DEPTH = 256
) (
  input  logic       clk,
  input  logic       rst,
  kmpd_req_if.sink   req,
  kmpd_rsp_if.source rsp,
  kmpd_cfg_if.sink   cfg
);

  kmpd_pkg::cfg_t regs;
  logic           cmd_in_valid;
  logic           cmd_in_ready;
  kmpd_pkg::cmd_t cmd_in;
  logic           cmd_out_valid;
  logic           cmd_out_ready;
  kmpd_pkg::cmd_t cmd_out;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.hdr_min <= kmpd_pkg::HDR_MIN_RESET;
      regs.x_limit <= kmpd_pkg::X_LIMIT_RESET;
      regs.y_limit <= kmpd_pkg::Y_LIMIT_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        kmpd_pkg::CFG_HDR_MIN: regs.hdr_min <= cfg.data[7:0];
        kmpd_pkg::CFG_X_LIMIT: regs.x_limit <= cfg.data;
        kmpd_pkg::CFG_Y_LIMIT: regs.y_limit <= cfg.data;
        default: ;
      endcase
    end
  end

  kmpd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .hdr_min   (regs.hdr_min),
    .cmd_valid (cmd_in_valid),
    .cmd       (cmd_in),
    .cmd_ready (cmd_in_ready)
  );

  kmpd_cmd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (cmd_in_valid),
    .push_ready (cmd_in_ready),
    .push_cmd   (cmd_in),
    .pop_valid  (cmd_out_valid),
    .pop_ready  (cmd_out_ready),
    .pop_cmd    (cmd_out)
  );

  kmpd_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (regs),
    .cmd_valid (cmd_out_valid),
    .cmd_ready (cmd_out_ready),
    .cmd       (cmd_out),
    .rsp       (rsp)
  );

endmodule
`default_nettype wire

### sim/tb_keyboard_mouse_packet_decoder.sv
`default_nettype none
module tb_keyboard_mouse_packet_decoder;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int KEY_DEPTH = 256;
  localparam int CYCLE_LIMIT = 600000;
  localparam int HOLD_CYCLES = 300;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_DX,
    PH_DY
  } pkt_phase_t;

  typedef struct {
    logic       op;
    logic [7:0] data;
  } kbd_req_t;

  typedef struct {
    logic [7:0] popped_key;
    logic       pop_valid;
    logic       pending;
    logic [7:0] next_key;
    logic [8:0] queue_fill;
    logic [9:0] pointer_x;
    logic [9:0] pointer_y;
    logic       key_held;
    logic       overflow;
  } kbd_status_t;

  localparam logic [7:0] ASCII_MAP [0:127] = '{
    8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
    8'h37, 8'h38, 8'h39, 8'h30, 8'h2D, 8'h3D, 8'h08, 8'h09,
    8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69,
    8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0D, 8'h00, 8'h61, 8'h73,
    8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B,
    8'h27, 8'h60, 8'h00, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76,
    8'h62, 8'h6E, 8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'h00, 8'h00,
    8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h2D, 8'h00, 8'h00, 8'h00, 8'h2B, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h7F, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h28, 8'h29, 8'h2F, 8'h2A, 8'h37, 8'h38, 8'h39,
    8'h34, 8'h35, 8'h36, 8'h31, 8'h32, 8'h33, 8'h30, 8'h2E,
    8'h0D, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
  };

  logic clk = 1'b0;
  logic rst = 1'b1;

  kmpd_req_if req_ch ();
  kmpd_rsp_if rsp_ch ();
  kmpd_cfg_if cfg_ch ();

  keyboard_mouse_packet_decoder #(
    .QUEUE_DEPTH(KEY_DEPTH)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch),
    .cfg(cfg_ch)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // predicted decoder state
  logic [7:0]  key_mem [0:KEY_DEPTH-1];
  logic [7:0]  key_rd = '0;
  logic [7:0]  key_wr = '0;
  logic [8:0]  key_count = '0;
  pkt_phase_t  pkt_phase = PH_IDLE;
  logic [9:0]  pos_x = kmpd_pkg::POS_X_RESET;
  logic [9:0]  pos_y = kmpd_pkg::POS_Y_RESET;
  logic        held = 1'b0;
  logic        dropped = 1'b0;
  logic [7:0]  hdr_min = kmpd_pkg::HDR_MIN_RESET;
  logic [9:0]  x_lim = kmpd_pkg::X_LIMIT_RESET;
  logic [9:0]  y_lim = kmpd_pkg::Y_LIMIT_RESET;

  kbd_req_t    req_todo_q[$];
  kbd_status_t status_want_q[$];

  logic [7:0]  gen_hdr = kmpd_pkg::HDR_MIN_RESET;
  bit          no_idle = 1'b0;
  bit          hold_go = 1'b0;
  bit          hold_on = 1'b0;
  bit          req_done = 1'b0;
  int          req_wait = 0;
  int          rsp_wait = 0;
  int          cycle_cnt = 0;
  int          mismatches = 0;
  int          n_reqs = 0;
  int          n_popped = 0;
  int          n_packets = 0;
  int          n_drops = 0;
  int          peak_fill = 0;

  initial begin
    req_ch.valid = 1'b0;
    req_ch.operation = kmpd_pkg::OP_BYTE;
    req_ch.data_byte = '0;
    rsp_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = kmpd_pkg::CFG_HDR_MIN;
    cfg_ch.data = '0;
  end

  function automatic int idle_len();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [9:0] clamp_move(input logic [9:0] pos, input logic [7:0] d,
                                            input logic [9:0] lim);
    int s;
    s = int'(pos) + int'($signed(d));
    if (s < 0) s = 0;
    if (s > int'(lim)) s = int'(lim);
    return s[9:0];
  endfunction

  function automatic void push_key(input logic [7:0] v);
    if (key_count >= KEY_DEPTH) begin
      dropped = 1'b1;
      n_drops++;
    end else begin
      key_mem[key_wr] = v;
      key_wr = key_wr + 8'd1;
      key_count = key_count + 9'd1;
      if (key_count > peak_fill) peak_fill = key_count;
    end
  endfunction

  function automatic kbd_status_t apply_request(input logic op, input logic [7:0] b);
    kbd_status_t s;
    s.popped_key = '0;
    s.pop_valid = 1'b0;
    n_reqs++;
    if (op == kmpd_pkg::OP_POP) begin
      if (key_count > 0) begin
        s.popped_key = key_mem[key_rd];
        s.pop_valid = 1'b1;
        key_rd = key_rd + 8'd1;
        key_count = key_count - 9'd1;
        n_popped++;
      end
    end else begin
      case (pkt_phase)
        PH_IDLE: begin
          if (b < hdr_min) begin
            if (!b[7]) begin
              push_key((b < kmpd_pkg::MAP_ENTRIES) ? ASCII_MAP[b[6:0]] : 8'h00);
              held = 1'b1;
            end else begin
              held = 1'b0;
            end
          end else begin
            push_key(b);
            pkt_phase = PH_DX;
            n_packets++;
          end
        end
        PH_DX: begin
          pos_x = clamp_move(pos_x, b, x_lim);
          pkt_phase = PH_DY;
        end
        default: begin
          pos_y = clamp_move(pos_y, b, y_lim);
          pkt_phase = PH_IDLE;
        end
      endcase
    end
    s.pending = (key_count > 0);
    s.next_key = (key_count > 0) ? key_mem[key_rd] : 8'h00;
    s.queue_fill = key_count;
    s.pointer_x = pos_x;
    s.pointer_y = pos_y;
    s.key_held = held;
    s.overflow = dropped;
    return s;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want)
      report_mismatch($sformatf("%s got %0d, want %0d", name, got, want));
  endtask

  // request driver
  always @(negedge clk) begin
    kbd_req_t nxt;
    if (!rst && (!req_ch.valid || req_done)) begin
      if (req_wait > 0) begin
        req_wait--;
        req_ch.valid <= 1'b0;
      end else if (req_todo_q.size() > 0) begin
        nxt = req_todo_q.pop_front();
        req_ch.valid <= 1'b1;
        req_ch.operation <= nxt.op;
        req_ch.data_byte <= nxt.data;
        req_wait = idle_len();
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // result acceptor
  always @(negedge clk) begin
    if (rst || hold_on) begin
      rsp_ch.ready <= 1'b0;
    end else if (rsp_wait > 0) begin
      rsp_wait--;
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= 1'b1;
      rsp_wait = idle_len();
    end
  end

  // long receiver hold-off
  initial begin
    wait (hold_go);
    @(posedge clk);
    hold_on = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_on = 1'b0;
  end

  // monitor
  always @(posedge clk) begin
    kbd_status_t got;
    kbd_status_t want;
    req_done = 1'b0;
    if (!rst) begin
      if (req_ch.valid && req_ch.ready) begin
        status_want_q.push_back(apply_request(req_ch.operation, req_ch.data_byte));
        req_done = 1'b1;
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          kmpd_pkg::CFG_HDR_MIN: hdr_min = cfg_ch.data[7:0];
          kmpd_pkg::CFG_X_LIMIT: x_lim = cfg_ch.data;
          kmpd_pkg::CFG_Y_LIMIT: y_lim = cfg_ch.data;
          default: ;
        endcase
      end
      if (rsp_ch.valid && rsp_ch.ready) begin
        got.popped_key = rsp_ch.popped_key;
        got.pop_valid = rsp_ch.pop_valid;
        got.pending = rsp_ch.pending;
        got.next_key = rsp_ch.next_key;
        got.queue_fill = rsp_ch.queue_fill;
        got.pointer_x = rsp_ch.pointer_x;
        got.pointer_y = rsp_ch.pointer_y;
        got.key_held = rsp_ch.key_held;
        got.overflow = rsp_ch.overflow;
        if (status_want_q.size() == 0) begin
          report_mismatch("result with no request outstanding");
        end else begin
          want = status_want_q.pop_front();
          check_field("popped_key", got.popped_key, want.popped_key);
          check_field("pop_valid", got.pop_valid, want.pop_valid);
          check_field("pending", got.pending, want.pending);
          check_field("next_key", got.next_key, want.next_key);
          check_field("queue_fill", got.queue_fill, want.queue_fill);
          check_field("pointer_x", got.pointer_x, want.pointer_x);
          check_field("pointer_y", got.pointer_y, want.pointer_y);
          check_field("key_held", got.key_held, want.key_held);
          check_field("overflow", got.overflow, want.overflow);
        end
      end
    end
  end

  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("timeout after %0d cycles", cycle_cnt);
    $display("Simulation FAILED");
    $finish;
  end

  task automatic queue_req(input logic op, input logic [7:0] d);
    kbd_req_t r;
    r.op = op;
    r.data = d;
    req_todo_q.push_back(r);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [9:0] val);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic set_regs(input logic [7:0] hdr, input logic [9:0] xl, input logic [9:0] yl);
    write_reg(kmpd_pkg::CFG_HDR_MIN, {2'b00, hdr});
    write_reg(kmpd_pkg::CFG_X_LIMIT, xl);
    write_reg(kmpd_pkg::CFG_Y_LIMIT, yl);
    gen_hdr = hdr;
  endtask

  task automatic wait_idle();
    while (req_todo_q.size() > 0 || req_ch.valid || status_want_q.size() > 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [7:0] make_byte();
    int lim;
    lim = (gen_hdr < 128) ? gen_hdr : 128;
    if (lim == 0) return 8'($urandom);
    if (lim > 115 && $urandom_range(0, 5) == 0) return 8'($urandom_range(115, lim - 1));
    return 8'($urandom_range(0, lim - 1));
  endfunction

  function automatic logic [7:0] break_byte();
    if (gen_hdr > 128) return 8'($urandom_range(128, gen_hdr - 1));
    return 8'($urandom_range(128, 255));
  endfunction

  function automatic logic [7:0] delta_byte();
    case ($urandom_range(0, 7))
      0: return 8'h7F;
      1: return 8'h80;
      2: return 8'h00;
      3: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic add_traffic(input int n, input int pop_pct);
    int made;
    int r;
    made = 0;
    while (made < n) begin
      r = $urandom_range(0, 99);
      if (r < pop_pct) begin
        queue_req(kmpd_pkg::OP_POP, 8'($urandom));
        made++;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 12) begin
          queue_req(kmpd_pkg::OP_BYTE, 8'($urandom));
          made++;
        end else if (r < 45) begin
          // mouse packet, sometimes with a pop inside or cut short
          queue_req(kmpd_pkg::OP_BYTE, 8'($urandom_range(gen_hdr, 255)));
          if ($urandom_range(0, 9) == 0) begin
            queue_req(kmpd_pkg::OP_POP, 8'($urandom));
            made++;
          end
          queue_req(kmpd_pkg::OP_BYTE, delta_byte());
          made += 2;
          if ($urandom_range(0, 7) != 0) begin
            queue_req(kmpd_pkg::OP_BYTE, delta_byte());
            made++;
          end
        end else if (r < 80) begin
          queue_req(kmpd_pkg::OP_BYTE, make_byte());
          made++;
        end else begin
          queue_req(kmpd_pkg::OP_BYTE, break_byte());
          made++;
        end
      end
    end
  endtask

  task automatic run_phase(input logic [7:0] hdr, input logic [9:0] xl, input logic [9:0] yl,
                           input int n, input int pop_pct, input bit quiet);
    set_regs(hdr, xl, yl);
    no_idle = quiet;
    add_traffic(n, pop_pct);
    wait_idle();
    no_idle = 1'b0;
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed requests at reset settings
    queue_req(kmpd_pkg::OP_POP, 8'hFF);
    queue_req(kmpd_pkg::OP_BYTE, 8'h01);
    queue_req(kmpd_pkg::OP_BYTE, 8'h1C);
    queue_req(kmpd_pkg::OP_BYTE, 8'h53);
    queue_req(kmpd_pkg::OP_BYTE, 8'h00);
    queue_req(kmpd_pkg::OP_BYTE, 8'h72);
    queue_req(kmpd_pkg::OP_BYTE, 8'h73);
    queue_req(kmpd_pkg::OP_BYTE, 8'h7F);
    queue_req(kmpd_pkg::OP_BYTE, 8'h81);
    queue_req(kmpd_pkg::OP_BYTE, 8'hF7);
    queue_req(kmpd_pkg::OP_BYTE, 8'hF8);
    queue_req(kmpd_pkg::OP_BYTE, 8'h7F);
    queue_req(kmpd_pkg::OP_POP, 8'h00);
    queue_req(kmpd_pkg::OP_BYTE, 8'h80);
    repeat (3) begin
      queue_req(kmpd_pkg::OP_BYTE, 8'hFF);
      queue_req(kmpd_pkg::OP_BYTE, 8'h7F);
      queue_req(kmpd_pkg::OP_BYTE, 8'h7F);
    end
    queue_req(kmpd_pkg::OP_POP, 8'h00);
    queue_req(kmpd_pkg::OP_POP, 8'h00);
    wait_idle();

    // pointer now sits above these limits
    run_phase(8'd128, 10'd100, 10'd50, 200, 25, 1'b0);
    run_phase(8'd0, 10'd1023, 10'd1023, 200, 30, 1'b0);
    run_phase(8'd255, 10'd0, 10'd0, 200, 30, 1'b1);

    // fill the key queue past its depth, then drain it
    set_regs(8'd248, 10'd1023, 10'd1023);
    repeat (280) queue_req(kmpd_pkg::OP_BYTE, make_byte());
    wait_idle();
    repeat (280) queue_req(kmpd_pkg::OP_POP, 8'($urandom));
    wait_idle();

    // receiver holds off while requests keep coming
    set_regs(8'd200, 10'd700, 10'd500);
    no_idle = 1'b1;
    add_traffic(200, 20);
    hold_go = 1'b1;
    wait_idle();
    no_idle = 1'b0;

    repeat (2)
      run_phase(8'($urandom), 10'($urandom), 10'($urandom), 240, 35, 1'b0);

    wait_idle();
    repeat (10) @(posedge clk);
    if (status_want_q.size() > 0)
      report_mismatch($sformatf("%0d results never arrived", status_want_q.size()));
    $display("covered %0d requests, %0d keys popped, %0d mouse packets",
             n_reqs, n_popped, n_packets);
    $display("peak queue fill %0d, %0d dropped pushes, %0d mismatches",
             peak_fill, n_drops, mismatches);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
